// File: rtl/lkvc_pkg.sv
`default_nettype none

package lkvc_pkg;

  // Field widths of the command, response and configuration beats
  localparam int CMD_W   = 1;
  localparam int KEY_W   = 32;
  localparam int VALUE_W = 32;
  localparam int OCC_W   = 5;
  localparam int CAP_W   = 5;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_GET = 1'b0;
  localparam logic [CMD_W-1:0] CMD_PUT = 1'b1;

  // Capacity after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Broadcast control from the top level to every cell
  typedef struct packed {
    logic update;  // apply this command to the chain
    logic hit;     // key found somewhere in the chain
    logic insert;  // put of an absent key: shift the whole chain
  } lkvc_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/lkvc_intf.sv
`default_nettype none

// Command channel: one get or put per beat
interface lkvc_cmd_if;
  import lkvc_pkg::*;
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [KEY_W-1:0]   key;
  logic [VALUE_W-1:0] value;

  modport source (output valid, command, key, value, input ready);
  modport sink   (input valid, command, key, value, output ready);
endinterface

// Response channel: one result per command
interface lkvc_rsp_if;
  import lkvc_pkg::*;
  logic               valid;
  logic               ready;
  logic               hit;
  logic [VALUE_W-1:0] read_value;
  logic [OCC_W-1:0]   occupancy;

  modport source (output valid, hit, read_value, occupancy, input ready);
  modport sink   (input valid, hit, read_value, occupancy, output ready);
endinterface

// Capacity write channel
interface lkvc_cfg_if;
  import lkvc_pkg::*;
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// File: rtl/lkvc_cell.sv
`default_nettype none

module lkvc_cell
  import lkvc_pkg::*;
#(
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32,
  parameter int CW          = 5,
  parameter int INDEX       = 0
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire lkvc_ctrl_t             ctrl,
  input  wire logic [CW-1:0]          cap,
  input  wire logic [KEY_WIDTH-1:0]   look_key,
  input  wire logic [KEY_WIDTH-1:0]   prev_key,
  input  wire logic [VALUE_WIDTH-1:0] prev_value,
  input  wire logic                   prev_valid,
  input  wire logic                   seen_in,
  output logic      [KEY_WIDTH-1:0]   key,
  output logic      [VALUE_WIDTH-1:0] value,
  output logic                        valid,
  output logic                        match,
  output logic                        seen_out
);

  logic shift;
  logic in_cap;

  // Compare against the broadcast key; pass the match toward the head
  assign match    = valid && (key == look_key);
  assign seen_out = match || seen_in;

  // Shift when the hit lies here or further down, or on an insert
  assign shift  = ctrl.update && (ctrl.insert || (ctrl.hit && seen_out));
  assign in_cap = CW'(INDEX) < cap;

  // Hold the slot valid flag; an insert drops slots past the capacity
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= prev_valid && (!ctrl.insert || in_cap);
    end
  end

  // Take key and value from the neighbor closer to the head
  always_ff @(posedge clk) begin
    if (shift) begin
      key   <= prev_key;
      value <= prev_value;
    end
  end

endmodule

`default_nettype wire

// File: rtl/lru_key_value_cache_unit.sv
`default_nettype none

// LRU key/value cache.
// cmd carries one get (command 0) or put (command 1) with a key and a value.
// rsp returns one beat per command: hit, the value read by a get hit (zero
// otherwise) and the number of entries held after the command.
// cfg writes the capacity (0 acts as 1, above ENTRIES acts as ENTRIES); write
// it only while no command is in flight. cfg is always ready.
// Entries sit in a chain of ENTRIES cells, most recent at cell 0. Every cell
// compares its key in the same cycle; on a hit the cells up to the match
// shift one place and the entry moves to cell 0, an insert shifts the whole
// chain and the tail is dropped past the capacity.
// Flow: a command is taken in the idle state and applied to the chain in the
// exec state, which also loads the response register that drives rsp.valid. No
// new command is taken until the current one has been applied. The chain
// update is the single apply step between a command and its response.
// Reset empties the cache at once (no clearing pass) and sets capacity 16.
// If rsp stalls, the response is held and the next command is taken but
// waits in the apply step until the held beat leaves.

module lru_key_value_cache_unit
  import lkvc_pkg::*;
#(
  parameter int ENTRIES     = 16,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  lkvc_cmd_if.sink  cmd,
  lkvc_rsp_if.source rsp,
  lkvc_cfg_if.sink  cfg
);

  localparam int CW = $clog2(ENTRIES + 1);

  typedef enum logic [0:0] {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t             state;
  logic [CMD_W-1:0]   req_cmd;
  logic [KEY_W-1:0]   req_key;
  logic [VALUE_W-1:0] req_value;
  logic [CW-1:0]      count;
  logic [CAP_W-1:0]   capacity;
  logic               rsp_valid;
  logic               rsp_hit;
  logic [VALUE_W-1:0] rsp_read;
  logic [OCC_W-1:0]   rsp_occ;

  lkvc_ctrl_t             ctrl;
  logic                   go;
  logic                   is_put;
  logic [CW-1:0]          cap_eff;
  logic [31:0]            cap_wide;
  logic [31:0]            cap_sel;
  logic [CW-1:0]          count_top;
  logic [CW-1:0]          count_ins;
  logic [CW-1:0]          count_next;
  logic [31:0]            occ_wide;
  logic [63:0]            key_ext;
  logic [63:0]            value_ext;
  logic [63:0]            read_ext;
  logic [KEY_WIDTH-1:0]   look_key;
  logic [VALUE_WIDTH-1:0] put_value;
  logic [VALUE_WIDTH-1:0] hit_value;
  logic [VALUE_W-1:0]     rsp_read_next;

  logic [KEY_WIDTH-1:0]   prev_key   [ENTRIES];
  logic [VALUE_WIDTH-1:0] prev_value [ENTRIES];
  logic                   prev_valid [ENTRIES];
  logic [KEY_WIDTH-1:0]   cell_key   [ENTRIES];
  logic [VALUE_WIDTH-1:0] cell_value [ENTRIES];
  logic                   cell_valid [ENTRIES];
  logic                   cell_match [ENTRIES];
  logic                   seen       [ENTRIES+1];

  assign cmd.ready      = (state == S_IDLE);
  assign cfg.ready      = 1'b1;
  assign rsp.valid      = rsp_valid;
  assign rsp.hit        = rsp_hit;
  assign rsp.read_value = rsp_read;
  assign rsp.occupancy  = rsp_occ;

  // Fit the held key and value to the stored widths
  assign key_ext   = 64'(req_key);
  assign value_ext = 64'(req_value);
  assign look_key  = key_ext[KEY_WIDTH-1:0];
  assign put_value = value_ext[VALUE_WIDTH-1:0];
  assign is_put    = (req_cmd == CMD_PUT);

  // Clamp the capacity register to 1..ENTRIES
  assign cap_wide = 32'(capacity);
  always_comb begin
    if (cap_wide == 32'd0) begin
      cap_sel = 32'd1;
    end else if (cap_wide > 32'(ENTRIES)) begin
      cap_sel = 32'(ENTRIES);
    end else begin
      cap_sel = cap_wide;
    end
  end
  assign cap_eff = cap_sel[CW-1:0];

  // Broadcast control: the chain reports a hit at its head
  assign go          = (state == S_EXEC) && (!rsp_valid || rsp.ready);
  assign ctrl.update = go;
  assign ctrl.hit    = seen[0];
  assign ctrl.insert = !seen[0] && is_put;

  // Gather the value of the single matching cell
  always_comb begin
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (cell_match[i]) begin
        hit_value = hit_value | cell_value[i];
      end
    end
  end

  // Occupancy after the command; an insert adds one, up to the capacity
  assign count_top  = (count > CW'(ENTRIES - 1)) ? CW'(ENTRIES - 1) : count;
  assign count_ins  = count_top + CW'(1);
  assign count_next = ctrl.insert ? ((count_ins > cap_eff) ? cap_eff : count_ins) : count;
  assign occ_wide   = 32'(count_next);

  assign read_ext      = 64'(hit_value);
  assign rsp_read_next = (ctrl.hit && !is_put) ? read_ext[VALUE_W-1:0] : '0;

  // Feed the head of the chain with the entry that becomes most recent
  assign prev_key[0]   = look_key;
  assign prev_value[0] = is_put ? put_value : hit_value;
  assign prev_valid[0] = 1'b1;
  assign seen[ENTRIES] = 1'b0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    if (g > 0) begin : g_link
      assign prev_key[g]   = cell_key[g-1];
      assign prev_value[g] = cell_value[g-1];
      assign prev_valid[g] = cell_valid[g-1];
    end

    lkvc_cell #(
      .KEY_WIDTH   (KEY_WIDTH),
      .VALUE_WIDTH (VALUE_WIDTH),
      .CW          (CW),
      .INDEX       (g)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .cap        (cap_eff),
      .look_key   (look_key),
      .prev_key   (prev_key[g]),
      .prev_value (prev_value[g]),
      .prev_valid (prev_valid[g]),
      .seen_in    (seen[g+1]),
      .key        (cell_key[g]),
      .value      (cell_value[g]),
      .valid      (cell_valid[g]),
      .match      (cell_match[g]),
      .seen_out   (seen[g])
    );
  end

  // Capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg.valid && cfg.ready) begin
      capacity <= cfg.data;
    end
  end

  // Hold the command beat
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      req_cmd   <= cmd.command;
      req_key   <= cmd.key;
      req_value <= cmd.value;
    end
  end

  // Sequencer, entry count and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp.ready && !go) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (go) begin
            count     <= count_next;
            rsp_valid <= 1'b1;
            rsp_hit   <= ctrl.hit;
            rsp_read  <= rsp_read_next;
            rsp_occ   <= occ_wide[OCC_W-1:0];
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/lkvc_checker.sv
`default_nettype none

module lkvc_checker
  import lkvc_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               cmd_valid,
  input wire logic               cmd_ready,
  input wire logic               rsp_valid,
  input wire logic               rsp_ready,
  input wire logic               rsp_hit,
  input wire logic [VALUE_W-1:0] rsp_read_value,
  input wire logic [OCC_W-1:0]   rsp_occupancy
);

  // A stalled response beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_hit) &&
      $stable(rsp_read_value) && $stable(rsp_occupancy)))
    else $error("response changed while stalled");

  // A command beat is followed by a cycle in which no command is taken
  a_cmd_spacing: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |=> !cmd_ready)
    else $error("command taken in the apply cycle");

  // Misses read zero; a put hit also reads zero, but is not checked here
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_hit) |-> (rsp_read_value == '0))
    else $error("nonzero read value on a miss");

  // Occupancy stays within the chain length
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ((32'(rsp_occupancy) <= 32'(ENTRIES)) || (ENTRIES > 31)))
    else $error("occupancy above the number of entries");

  // Reset leaves no response pending
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

endmodule

bind lru_key_value_cache_unit lkvc_checker #(
  .ENTRIES (ENTRIES)
) u_lkvc_checker (
  .clk            (clk),
  .rst            (rst),
  .cmd_valid      (cmd.valid),
  .cmd_ready      (cmd.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_hit        (rsp.hit),
  .rsp_read_value (rsp.read_value),
  .rsp_occupancy  (rsp.occupancy)
);

`default_nettype wire
